@@ rtl/core/zpfir_pkg.sv @@
package zpfir_pkg;

  // kernel length limit, sizes both stores
  localparam int unsigned MAX_TAPS = 16;
  localparam int unsigned TAP_AW   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int unsigned TAP_CW   = $clog2(MAX_TAPS + 1);
  // 16x16 products summed over up to MAX_TAPS taps
  localparam int unsigned ACC_W    = 32 + TAP_AW;
  // width for the emit compare (samples seen + flush count + 1)
  localparam int unsigned CMP_W    = 8;

  localparam int unsigned DATA_W    = 16;
  localparam int unsigned CFG_W     = 5;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned SEEN_W    = 5;

  typedef enum logic [0:0] {
    ACT_COEF   = 1'b0,
    ACT_SAMPLE = 1'b1
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TAP_COUNT    = 1'b0,
    CFG_OUTPUT_SHIFT = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_FLUSH = 4'b0010,
    ST_MAC   = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

  typedef struct packed {
    action_e                   action;
    logic [3:0]                coef_index;
    logic signed [DATA_W-1:0]  coef_value;
    logic signed [DATA_W-1:0]  sample;
    logic                      end_of_signal;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  result_sample;
    logic                      saturated;
    logic                      result_last;
  } out_item_t;

  // zero means one tap, anything above the store depth means all taps
  function automatic logic [TAP_CW-1:0] taps_used(input logic [CFG_W-1:0] tc);
    if (tc == '0) begin
      return TAP_CW'(1);
    end else if (32'(tc) > MAX_TAPS) begin
      return TAP_CW'(MAX_TAPS);
    end else begin
      return TAP_CW'(tc);
    end
  endfunction

endpackage

@@ rtl/core/zpfir_ram.sv @@
module zpfir_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16,
  localparam int unsigned Aw   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/zero_padded_fir_convolver_core.sv @@
// channel  | direction | handshake              | payload
// ---------+-----------+------------------------+---------------------------------
// in       | input     | in_valid_i / in_stall_o | in_item_i  (in_item_t)
// out      | output    | out_valid_o / out_stall_i | out_item_o (out_item_t)
// cfg      | input     | cfg_we_i (no wait)     | cfg_idx_i, cfg_data_i
//
// coefficient items and samples with no output do not hold the input; a sample with an output
// holds the input until its result is loaded (k = taps in use), the result set by one
// multiply-accumulate walking both memories a tap per cycle plus drain
// end of signal adds k - 1 zero pushes, each of which runs that multiply-accumulate when it emits
// reset is asynchronous: both stores read as zero through per-entry valid bits
// a stalled output holds only the emit step; the next item is taken while a result waits
module zero_padded_fir_convolver_core
  import zpfir_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_item_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  // configuration registers
  logic [CFG_W-1:0] tap_count_q, output_shift_q;

  // sequencer state
  state_e             state_q, state_d;
  logic [SEEN_W-1:0]  samples_seen_q, samples_seen_d;
  logic [TAP_AW-1:0]  head_q, head_d;
  logic [TAP_CW-1:0]  k_q, k_d;
  logic [SEEN_W-1:0]  pos_q, pos_d;
  logic [TAP_AW-1:0]  z_q, z_d;
  logic               eos_q, eos_d;
  logic [TAP_CW-1:0]  t_q, t_d;

  // mac pipeline
  logic                     rd_v_q, prod_v_q;
  logic                     coef_vld_rd_q, dl_vld_rd_q;
  logic signed [31:0]       prod_q;
  logic signed [ACC_W-1:0]  acc_q;

  // per-entry valid bits, a cleared entry reads as zero
  logic [MAX_TAPS-1:0] coef_vld_q, dl_vld_q;

  // output register
  logic       out_valid_q;
  out_item_t  out_item_q;

  // memory ports
  logic                     coef_we, dl_we;
  logic [TAP_AW-1:0]        coef_waddr, dl_waddr, coef_raddr, dl_raddr;
  logic [DATA_W-1:0]        coef_wdata, dl_wdata, coef_rdata, dl_rdata;

  logic               in_acc, is_sample, issue_en, mac_start, mac_done, out_load;
  logic [TAP_AW-1:0]  head_dec;
  logic [TAP_AW:0]    rd_sum;
  logic [TAP_CW-1:0]  k_new;
  logic               emit_first, emit_flush, more_flush;
  logic [TAP_AW-1:0]  z_inc;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_sample  = (in_item_i.action == ACT_SAMPLE);

  // circular delay line: a push writes just below the head, tap t sits at head + t
  assign head_dec = (head_q == '0) ? TAP_AW'(MAX_TAPS - 1) : head_q - TAP_AW'(1);
  assign rd_sum   = {1'b0, head_q} + (TAP_AW + 1)'(t_q);
  assign dl_raddr = (rd_sum >= (TAP_AW + 1)'(MAX_TAPS))
                    ? TAP_AW'(rd_sum - (TAP_AW + 1)'(MAX_TAPS)) : TAP_AW'(rd_sum);
  assign coef_raddr = TAP_AW'(t_q);

  assign k_new = taps_used(tap_count_q);
  assign z_inc = z_q + TAP_AW'(1);

  // an output is due once pos + pushes >= k
  assign emit_first = (CMP_W'(samples_seen_q) + CMP_W'(1)) >= CMP_W'(k_new);
  assign emit_flush = (CMP_W'(pos_q) + CMP_W'(z_inc) + CMP_W'(1)) >= CMP_W'(k_q);
  assign more_flush = eos_q && ((CMP_W'(z_q) + CMP_W'(1)) < CMP_W'(k_q));

  assign issue_en = (state_q == ST_MAC) && (t_q < k_q);
  assign mac_done = (state_q == ST_MAC) && (t_q == k_q) && !rd_v_q && !prod_v_q;
  assign out_load = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);

  // memory write side
  always_comb begin
    coef_we    = in_acc && !is_sample && (32'(in_item_i.coef_index) < MAX_TAPS);
    coef_waddr = TAP_AW'(in_item_i.coef_index);
    coef_wdata = in_item_i.coef_value;
    dl_we      = (in_acc && is_sample) || (state_q == ST_FLUSH);
    dl_waddr   = head_dec;
    // flush pushes zeros
    dl_wdata   = (state_q == ST_FLUSH) ? '0 : in_item_i.sample;
  end

  // sequencer
  always_comb begin
    state_d        = state_q;
    samples_seen_d = samples_seen_q;
    head_d         = head_q;
    k_d            = k_q;
    pos_d          = pos_q;
    z_d            = z_q;
    eos_d          = eos_q;
    t_d            = t_q;
    mac_start      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && is_sample) begin
          head_d = head_dec;
          k_d    = k_new;
          pos_d  = samples_seen_q;
          z_d    = '0;
          eos_d  = in_item_i.end_of_signal;
          if (in_item_i.end_of_signal) begin
            samples_seen_d = '0;
          end else if (samples_seen_q != '1) begin
            samples_seen_d = samples_seen_q + SEEN_W'(1);
          end
          if (emit_first) begin
            state_d   = ST_MAC;
            mac_start = 1'b1;
          end else if (in_item_i.end_of_signal) begin
            state_d = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        head_d = head_dec;
        z_d    = z_inc;
        if (emit_flush) begin
          state_d   = ST_MAC;
          mac_start = 1'b1;
        end
      end
      ST_MAC: begin
        if (issue_en) begin
          t_d = t_q + TAP_CW'(1);
        end
        if (mac_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          state_d = more_flush ? ST_FLUSH : ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (mac_start) begin
      t_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      samples_seen_q <= '0;
      head_q         <= '0;
      t_q            <= '0;
      rd_v_q         <= 1'b0;
      prod_v_q       <= 1'b0;
      coef_vld_q     <= '0;
      dl_vld_q       <= '0;
      out_valid_q    <= 1'b0;
      tap_count_q    <= CFG_W'(1);
      output_shift_q <= CFG_W'(15);
    end else begin
      state_q        <= state_d;
      samples_seen_q <= samples_seen_d;
      head_q         <= head_d;
      t_q            <= t_d;
      rd_v_q         <= issue_en;
      prod_v_q       <= rd_v_q;
      if (coef_we) begin
        coef_vld_q[coef_waddr] <= 1'b1;
      end
      if (dl_we) begin
        dl_vld_q[dl_waddr] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_TAP_COUNT:    tap_count_q    <= cfg_data_i;
          CFG_OUTPUT_SHIFT: output_shift_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // item context, held for the whole item
  always_ff @(posedge clk_i) begin
    k_q   <= k_d;
    pos_q <= pos_d;
    z_q   <= z_d;
    eos_q <= eos_d;
  end

  // memories
  zpfir_ram #(.Width(DATA_W), .Depth(MAX_TAPS)) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (coef_waddr),
    .wdata_i (coef_wdata),
    .raddr_i (coef_raddr),
    .rdata_o (coef_rdata)
  );

  zpfir_ram #(.Width(DATA_W), .Depth(MAX_TAPS)) u_dl_ram (
    .clk_i   (clk_i),
    .we_i    (dl_we),
    .waddr_i (dl_waddr),
    .wdata_i (dl_wdata),
    .raddr_i (dl_raddr),
    .rdata_o (dl_rdata)
  );

  // mac datapath: read, multiply, accumulate
  logic signed [DATA_W-1:0] coef_m, dl_m;
  assign coef_m = coef_vld_rd_q ? $signed(coef_rdata) : '0;
  assign dl_m   = dl_vld_rd_q   ? $signed(dl_rdata)   : '0;

  always_ff @(posedge clk_i) begin
    coef_vld_rd_q <= coef_vld_q[coef_raddr];
    dl_vld_rd_q   <= dl_vld_q[dl_raddr];
    prod_q        <= coef_m * dl_m;
    if (mac_start) begin
      acc_q <= '0;
    end else if (prod_v_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  // floor shift, then clip to 16 bits
  logic signed [ACC_W-1:0] shifted;
  logic                    sat_hi, sat_lo;
  out_item_t               emit_item;

  assign shifted = acc_q >>> output_shift_q;
  assign sat_hi  = !shifted[ACC_W-1] && (shifted[ACC_W-2:DATA_W-1] != '0);
  assign sat_lo  = shifted[ACC_W-1]  && (shifted[ACC_W-2:DATA_W-1] != '1);

  always_comb begin
    emit_item.saturated   = sat_hi || sat_lo;
    // the last push of a flush always emits, so it carries the last flag
    emit_item.result_last = eos_q && ((CMP_W'(z_q) + CMP_W'(1)) == CMP_W'(k_q));
    if (sat_hi) begin
      emit_item.result_sample = 16'sh7fff;
    end else if (sat_lo) begin
      emit_item.result_sample = 16'sh8000;
    end else begin
      emit_item.result_sample = shifted[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_item_q <= emit_item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // pipeline drained before the sum is used
  a_mac_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (!rd_v_q && !prod_v_q))
    else $error("emit with mac pipeline busy");

  // last flag only for an end-of-signal item
  a_last_in_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && emit_item.result_last) |-> eos_q)
    else $error("last flag outside end of signal");

  // end of signal restarts the sample count
  a_seen_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_sample && in_item_i.end_of_signal) |=> (samples_seen_q == '0))
    else $error("samples seen not cleared");

  // the delay-line head moves only with a push
  a_head_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !dl_we |=> (head_q == $past(head_q)))
    else $error("head moved without push");

  // a tap read is only issued from the mac state
  a_no_extra_tap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_MAC) |=> !rd_v_q || $past(issue_en))
    else $error("tap read outside mac");

endmodule
